/* hdl/assert_macros.svh */
// Assertion macros shared by the line rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle property, checked on every edge outside reset.
`define LR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Next-cycle implication, checked on every edge outside reset.
`define LR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

/* hdl/lr_pkg.sv */
// Shared types and constants of the line rasterizer.
`default_nettype none

package lr_pkg;

	localparam int FRAME_BITS    = 13;
	localparam int COLOR_BITS    = 24;
	localparam int CFG_ADDR_BITS = 2;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = 13'd640;
	localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;
	localparam logic [COLOR_BITS-1:0] DRAW_COLOR_RESET   = 24'd0;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_DRAW_COLOR   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [FRAME_BITS-1:0] frame_width;
		logic [FRAME_BITS-1:0] frame_height;
		logic [COLOR_BITS-1:0] draw_color;
	} cfg_t;

endpackage

`default_nettype wire

/* hdl/lr_front.sv */
// Front end: accepts transactions and classifies line setup into a queue command.
`default_nettype none

module lr_front #(
	parameter int COORD_BITS = 12,
	parameter int CMD_BITS   = 3 + 4 * (COORD_BITS + 1)
) (
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         kind,
	input  wire logic signed [COORD_BITS-1:0] x_start,
	input  wire logic signed [COORD_BITS-1:0] y_start,
	input  wire logic signed [COORD_BITS-1:0] x_end,
	input  wire logic signed [COORD_BITS-1:0] y_end,
	output logic                              push_valid,
	input  wire logic                         push_ready,
	output logic [CMD_BITS-1:0]               push_data
);
	import lr_pkg::*;

	localparam int CW = COORD_BITS + 1;

	typedef struct packed {
		logic                 start;
		logic                 steep;
		logic                 neg;
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] y0;
		logic [CW-1:0]        major;
		logic [CW-1:0]        minor;
	} cmd_t;

	logic signed [CW-1:0] x0, y0, x1, y1, dx, dy, other;
	logic [CW-1:0]        adx, ady;
	logic                 steep, swap;
	cmd_t                 cmd;

	always_comb begin
		x0 = {x_start[COORD_BITS-1], x_start};
		y0 = {y_start[COORD_BITS-1], y_start};
		x1 = {x_end[COORD_BITS-1], x_end};
		y1 = {y_end[COORD_BITS-1], y_end};
		dx = x1 - x0;
		dy = y1 - y0;
		adx = dx[CW-1] ? $unsigned(-dx) : $unsigned(dx);
		ady = dy[CW-1] ? $unsigned(-dy) : $unsigned(dy);
		steep = !(ady < adx);
		swap = steep ? (y0 > y1) : (x0 > x1);
		other = steep ? dx : dy;

		cmd.start = (kind == KIND_START);
		cmd.steep = steep;
		cmd.neg   = swap ? (!other[CW-1] && (other != '0)) : other[CW-1];
		cmd.x0    = swap ? x1 : x0;
		cmd.y0    = swap ? y1 : y0;
		cmd.major = steep ? ady : adx;
		cmd.minor = steep ? adx : ady;
	end

	assign push_data  = cmd;
	assign push_valid = in_valid;
	assign in_ready   = push_ready;

endmodule

`default_nettype wire

/* hdl/lr_fifo.sv */
// Small command queue between the front end and the stepper.
`default_nettype none

`include "assert_macros.svh"

module lr_fifo #(
	parameter int WIDTH = 55,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  head_valid,
	output logic [WIDTH-1:0]      head_data,
	input  wire logic             pop
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign push       = push_valid && push_ready;
	assign head_valid = (count_q != '0);
	assign head_data  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	`LR_ASSERT(a_count_range, count_q <= CNT_W'(DEPTH), "queue count above depth")
	`LR_ASSERT(a_pop_nonempty, !pop || (count_q != '0), "pop from empty queue")
	`LR_ASSERT_NEXT(a_push_holds, push && !pop, count_q != '0, "pushed entry lost")

endmodule

`default_nettype wire

/* hdl/lr_back.sv */
// Back end: Bresenham stepper followed by index multiply and output register.
`default_nettype none

`include "assert_macros.svh"

module lr_back #(
	parameter int COORD_BITS = 12,
	parameter int INDEX_BITS = 24,
	parameter int CMD_BITS   = 3 + 4 * (COORD_BITS + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire lr_pkg::cfg_t                  cfg,
	input  wire logic                          head_valid,
	input  wire logic [CMD_BITS-1:0]           head_data,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [COORD_BITS-1:0]       pixel_x,
	output logic signed [COORD_BITS-1:0]       pixel_y,
	output logic [INDEX_BITS-1:0]              pixel_index,
	output logic                               inside_res,
	output logic [lr_pkg::COLOR_BITS-1:0]      pixel_color,
	output logic                               last_pixel
);
	import lr_pkg::*;

	localparam int CW = COORD_BITS + 1;
	localparam int EW = CW + 2;
	localparam int WC = (CW - 1 > FRAME_BITS) ? CW - 1 : FRAME_BITS;
	localparam int PW = CW - 1 + FRAME_BITS + 1;

	typedef struct packed {
		logic                 start;
		logic                 steep;
		logic                 neg;
		logic signed [CW-1:0] x0;
		logic signed [CW-1:0] y0;
		logic [CW-1:0]        major;
		logic [CW-1:0]        minor;
	} cmd_t;

	cmd_t cmd;

	// stepper state
	logic                 busy_q, steep_q, neg_q;
	logic signed [CW-1:0] cur_x_q, cur_y_q;
	logic [CW-1:0]        major_q, minor_q, pixels_left_q;
	logic signed [EW-1:0] err_q;

	// pipeline
	logic                 valid_s1, inside_s1, last_s1;
	logic signed [CW-1:0] x_s1, y_s1;
	logic                 valid_s2, inside_s2, last_s2;
	logic signed [CW-1:0] x_s2, y_s2;
	logic [INDEX_BITS-1:0] index_s2;
	logic [COLOR_BITS-1:0] color_s2;

	logic                 ready_s1, ready_s2, emit, mstep, in_frame;
	logic signed [EW-1:0] minor_e, major_e, err_step, err_next;
	logic signed [EW-1:0] cmd_minor_e, cmd_major_e;
	logic signed [CW-1:0] minor_inc;
	logic [PW-1:0]        index_sum;

	always_comb begin
		cmd = cmd_t'(head_data);
		ready_s2 = !valid_s2 || out_ready;
		ready_s1 = !valid_s1 || ready_s2;
		emit = head_valid && !cmd.start && busy_q && ready_s1;
		pop  = head_valid && (cmd.start || !busy_q || ready_s1);

		minor_e  = $signed(EW'(minor_q));
		major_e  = $signed(EW'(major_q));
		mstep    = (err_q > 0);
		err_step = mstep ? (minor_e - major_e) : minor_e;
		err_next = err_q + (err_step <<< 1);
		minor_inc = neg_q ? {CW{1'b1}} : CW'(1);

		cmd_minor_e = $signed(EW'(cmd.minor));
		cmd_major_e = $signed(EW'(cmd.major));

		in_frame = !cur_x_q[CW-1] && !cur_y_q[CW-1]
			&& (WC'(cur_x_q[CW-2:0]) < WC'(cfg.frame_width))
			&& (WC'(cur_y_q[CW-2:0]) < WC'(cfg.frame_height));

		index_sum = PW'(y_s1[CW-2:0]) * PW'(cfg.frame_width) + PW'(x_s1[CW-2:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			steep_q       <= 1'b0;
			neg_q         <= 1'b0;
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			major_q       <= '0;
			minor_q       <= '0;
			err_q         <= '0;
			pixels_left_q <= '0;
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
		end else begin
			if (pop && cmd.start) begin
				busy_q        <= (cmd.major != '0);
				steep_q       <= cmd.steep;
				neg_q         <= cmd.neg;
				cur_x_q       <= cmd.x0;
				cur_y_q       <= cmd.y0;
				major_q       <= cmd.major;
				minor_q       <= cmd.minor;
				err_q         <= (cmd_minor_e <<< 1) - cmd_major_e;
				pixels_left_q <= cmd.major;
			end else if (emit) begin
				err_q <= err_next;
				if (steep_q) begin
					cur_y_q <= cur_y_q + CW'(1);
					if (mstep) begin
						cur_x_q <= cur_x_q + minor_inc;
					end
				end else begin
					cur_x_q <= cur_x_q + CW'(1);
					if (mstep) begin
						cur_y_q <= cur_y_q + minor_inc;
					end
				end
				pixels_left_q <= pixels_left_q - CW'(1);
				busy_q        <= (pixels_left_q != CW'(1));
			end
			if (ready_s1) begin
				valid_s1 <= emit;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && emit) begin
			x_s1      <= cur_x_q;
			y_s1      <= cur_y_q;
			inside_s1 <= in_frame;
			last_s1   <= (pixels_left_q == CW'(1));
		end
		if (ready_s2 && valid_s1) begin
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			inside_s2 <= inside_s1;
			last_s2   <= last_s1;
			index_s2  <= inside_s1 ? INDEX_BITS'(index_sum) : '0;
			color_s2  <= cfg.draw_color;
		end
	end

	assign out_valid   = valid_s2;
	assign pixel_x     = x_s2[COORD_BITS-1:0];
	assign pixel_y     = y_s2[COORD_BITS-1:0];
	assign pixel_index = index_s2;
	assign inside_res  = inside_s2;
	assign pixel_color = color_s2;
	assign last_pixel  = last_s2;

	`LR_ASSERT(a_idle_empty, busy_q || (pixels_left_q == '0), "idle with pixels left")
	`LR_ASSERT_NEXT(a_last_ends, emit && (pixels_left_q == CW'(1)), !busy_q, "busy after last pixel")
	`LR_ASSERT(a_emit_busy, !emit || busy_q, "pixel emitted while idle")

endmodule

`default_nettype wire

/* hdl/line_rasterizer.sv */
// Top level of the line rasterizer: configuration registers, front end, queue and stepper.
// A kind-0 transaction loads a line's endpoints and returns nothing; each kind-1 transaction
// returns one pixel of the current line, and none when no line is active. Transactions of
// either kind are taken one per clock while the queue is not full: the front end classifies
// each one and places it in a four-entry queue, and the stepper drains that queue at one
// pixel per clock while the output is not stalled, its rate set by the single add-and-compare
// error update. An accepted tick waits in the queue, the stepper registers its pixel, and the
// index multiply lands in the output register; output back-pressure can stall either step.
// Registers are written on their own channel, which is always ready, and must only change
// while no line pixel is pending.
`default_nettype none

module line_rasterizer #(
	parameter int COORD_BITS = 12,
	parameter int INDEX_BITS = 24
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              kind,
	input  wire logic signed [COORD_BITS-1:0]      x_start,
	input  wire logic signed [COORD_BITS-1:0]      y_start,
	input  wire logic signed [COORD_BITS-1:0]      x_end,
	input  wire logic signed [COORD_BITS-1:0]      y_end,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [COORD_BITS-1:0]           pixel_x,
	output logic signed [COORD_BITS-1:0]           pixel_y,
	output logic [INDEX_BITS-1:0]                  pixel_index,
	output logic                                   inside_res,
	output logic [lr_pkg::COLOR_BITS-1:0]          pixel_color,
	output logic                                   last_pixel,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lr_pkg::CFG_ADDR_BITS-1:0]  cfg_index,
	input  wire logic [lr_pkg::COLOR_BITS-1:0]     cfg_data
);
	import lr_pkg::*;

	localparam int CMD_BITS = 3 + 4 * (COORD_BITS + 1);

	cfg_t                cfg_q;
	logic                push_valid, push_ready, head_valid, pop;
	logic [CMD_BITS-1:0] push_data, head_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= FRAME_WIDTH_RESET;
			cfg_q.frame_height <= FRAME_HEIGHT_RESET;
			cfg_q.draw_color   <= DRAW_COLOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data[FRAME_BITS-1:0];
				CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[FRAME_BITS-1:0];
				CFG_DRAW_COLOR:   cfg_q.draw_color   <= cfg_data;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	lr_front #(
		.COORD_BITS (COORD_BITS),
		.CMD_BITS   (CMD_BITS)
	) u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	lr_fifo #(
		.WIDTH (CMD_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop)
	);

	lr_back #(
		.COORD_BITS (COORD_BITS),
		.INDEX_BITS (INDEX_BITS),
		.CMD_BITS   (CMD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head_valid  (head_valid),
		.head_data   (head_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_index (pixel_index),
		.inside_res  (inside_res),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

endmodule

`default_nettype wire

/* tb/sv/line_rasterizer_tb.sv */
// Self-checking testbench for the line rasterizer: directed lines, register settings and random traffic.
`default_nettype none

module line_rasterizer_tb;

	import lr_pkg::*;

	localparam int CB             = 12;
	localparam int IB             = 24;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic [IB-1:0]        index;
		logic                 in_frame;
		logic [COLOR_BITS-1:0] color;
		logic                 last;
	} pixel_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic                       kind;
	logic signed [CB-1:0]       x_start;
	logic signed [CB-1:0]       y_start;
	logic signed [CB-1:0]       x_end;
	logic signed [CB-1:0]       y_end;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [CB-1:0]       pixel_x;
	logic signed [CB-1:0]       pixel_y;
	logic [IB-1:0]              pixel_index;
	logic                       inside_res;
	logic [COLOR_BITS-1:0]      pixel_color;
	logic                       last_pixel;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_ADDR_BITS-1:0]   cfg_index;
	logic [COLOR_BITS-1:0]      cfg_data;

	line_rasterizer #(
		.COORD_BITS(CB),
		.INDEX_BITS(IB)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.x_start(x_start),
		.y_start(y_start),
		.x_end(x_end),
		.y_end(y_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_index(pixel_index),
		.inside_res(inside_res),
		.pixel_color(pixel_color),
		.last_pixel(last_pixel),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predicted line state and register copy
	logic [FRAME_BITS-1:0] frame_w = FRAME_WIDTH_RESET;
	logic [FRAME_BITS-1:0] frame_h = FRAME_HEIGHT_RESET;
	logic [COLOR_BITS-1:0] draw_c  = DRAW_COLOR_RESET;
	bit ln_busy  = 1'b0;
	bit ln_steep = 1'b0;
	bit ln_neg   = 1'b0;
	int ln_x = 0, ln_y = 0, ln_major = 0, ln_minor = 0, ln_err = 0, ln_left = 0;

	pixel_t pending_pixels[$];
	int mismatches  = 0;
	int idle_cycles = 0;
	int send_idle   = 0;
	int recv_idle   = 0;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int iabs(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(4095)) - 2048;
	endfunction

	function automatic int clamp_coord(input int v);
		if (v < -2048)
			return -2048;
		if (v > 2047)
			return 2047;
		return v;
	endfunction

	function automatic int line_length(input int xs, input int ys, input int xe, input int ye);
		int dx, dy;
		dx = iabs(xe - xs);
		dy = iabs(ye - ys);
		return (dx > dy) ? dx : dy;
	endfunction

	function automatic void bresenham_advance(input logic k, input logic signed [CB-1:0] xs,
			input logic signed [CB-1:0] ys, input logic signed [CB-1:0] xe,
			input logic signed [CB-1:0] ye);
		int x0, y0, x1, y1, t, md, w, h;
		bit mstep;
		pixel_t p;
		if (k == KIND_START) begin
			x0 = xs;
			y0 = ys;
			x1 = xe;
			y1 = ye;
			ln_steep = !(iabs(y1 - y0) < iabs(x1 - x0));
			if (ln_steep ? (y0 > y1) : (x0 > x1)) begin
				t = x0; x0 = x1; x1 = t;
				t = y0; y0 = y1; y1 = t;
			end
			ln_major = ln_steep ? (y1 - y0) : (x1 - x0);
			md = ln_steep ? (x1 - x0) : (y1 - y0);
			ln_neg = md < 0;
			ln_minor = iabs(md);
			ln_err = 2 * ln_minor - ln_major;
			ln_x = x0;
			ln_y = y0;
			ln_left = ln_major;
			ln_busy = ln_left > 0;
		end else if (ln_busy) begin
			w = frame_w;
			h = frame_h;
			p.in_frame = ln_x >= 0 && ln_y >= 0 && ln_x < w && ln_y < h;
			p.index = p.in_frame ? IB'(ln_x + ln_y * w) : '0;
			p.x = ln_x[CB-1:0];
			p.y = ln_y[CB-1:0];
			p.color = draw_c;
			p.last = (ln_left == 1);
			pending_pixels.push_back(p);
			mstep = ln_err > 0;
			ln_err += mstep ? 2 * (ln_minor - ln_major) : 2 * ln_minor;
			if (!ln_steep) begin
				ln_x++;
				if (mstep)
					ln_y += ln_neg ? -1 : 1;
			end else begin
				ln_y++;
				if (mstep)
					ln_x += ln_neg ? -1 : 1;
			end
			ln_left--;
			if (ln_left <= 0) begin
				ln_left = 0;
				ln_busy = 1'b0;
			end
		end
	endfunction

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		pixel_t got, exp_px;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FRAME_WIDTH:  frame_w = cfg_data[FRAME_BITS-1:0];
					CFG_FRAME_HEIGHT: frame_h = cfg_data[FRAME_BITS-1:0];
					CFG_DRAW_COLOR:   draw_c  = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				bresenham_advance(kind, x_start, y_start, x_end, y_end);
			if (out_valid && out_ready) begin
				got = '{pixel_x, pixel_y, pixel_index, inside_res, pixel_color, last_pixel};
				if (pending_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected pixel x=%0d y=%0d idx=%0d", pixel_x, pixel_y,
							pixel_index);
				end else begin
					exp_px = pending_pixels.pop_front();
					if (got.x !== exp_px.x || got.y !== exp_px.y ||
							got.index !== exp_px.index || got.in_frame !== exp_px.in_frame ||
							got.color !== exp_px.color || got.last !== exp_px.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("pixel mismatch: exp x=%0d y=%0d idx=%0d in=%0b col=%h last=%0b,",
								exp_px.x, exp_px.y, exp_px.index, exp_px.in_frame,
								exp_px.color, exp_px.last);
							$display(" got x=%0d y=%0d idx=%0d in=%0b col=%h last=%0b",
								got.x, got.y, got.index, got.in_frame, got.color,
								got.last);
						end
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("line_rasterizer_tb: errors");
				$finish;
			end
		end
	end

	task automatic send_item(input logic k, input int xs, input int ys, input int xe,
			input int ye);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		x_start  <= xs[CB-1:0];
		y_start  <= ys[CB-1:0];
		x_end    <= xe[CB-1:0];
		y_end    <= ye[CB-1:0];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_line(input int xs, input int ys, input int xe, input int ye,
			input int ticks);
		send_item(KIND_START, xs, ys, xe, ye);
		repeat (ticks)
			send_item(KIND_TICK, rand_coord(), rand_coord(), rand_coord(), rand_coord());
	endtask

	// wait for every pixel in flight, then for transactions still in the pipeline
	task automatic settle_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [COLOR_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed_lines();
		send_idle = 15;
		recv_idle = 70;
		send_item(KIND_TICK, 0, 0, 0, 0);
		send_line(5, 5, 5, 5, 1);
		send_line(0, 0, 5, 2, 5);
		send_line(0, 0, 3, -3, 3);
		send_line(-2048, -2048, 2047, 2047, 2);
		send_line(2047, -2048, -2048, 2047, 2);
		send_line(7, -2, -3, 1, 3);
		settle_block();
	endtask

	task automatic test_register_settings();
		send_idle = 70;
		recv_idle = 15;
		cfg_write(CFG_FRAME_WIDTH, 24'd1);
		cfg_write(CFG_FRAME_HEIGHT, 24'd1);
		cfg_write(CFG_DRAW_COLOR, 24'hFFFFFF);
		send_line(-1, -1, 2, 1, 3);
		send_line(0, 0, 0, 3, 3);
		settle_block();
		cfg_write(CFG_FRAME_WIDTH, 24'd4096);
		cfg_write(CFG_FRAME_HEIGHT, 24'd4096);
		cfg_write(CFG_DRAW_COLOR, 24'h000000);
		send_line(2047, 2047, 2040, 2044, 7);
		send_line(-3, 5, 4, 5, 7);
		send_line(2047, 0, 2047, 4, 4);
		settle_block();
		// upper data bits set: width masks to zero, height to 480
		cfg_write(CFG_FRAME_WIDTH, 24'hFFE000);
		cfg_write(CFG_FRAME_HEIGHT, 24'hFFE1E0);
		cfg_write(CFG_DRAW_COLOR, 24'h5A3C96);
		send_line(0, 0, 4, 1, 4);
		settle_block();
		cfg_write(CFG_FRAME_WIDTH, 24'hFFE280);
		cfg_write(CFG_FRAME_HEIGHT, 24'hFFE000);
		send_line(3, 3, 6, 9, 6);
		settle_block();
		cfg_write(CFG_FRAME_WIDTH, 24'd640);
		cfg_write(CFG_FRAME_HEIGHT, 24'd480);
	endtask

	task automatic test_random_traffic(input int s_idle, input int r_idle, input int n_items);
		int sent, xs, ys, xe, ye, ticks, pick;
		settle_block();
		send_idle = s_idle;
		recv_idle = r_idle;
		cfg_write(CFG_FRAME_WIDTH, COLOR_BITS'($urandom_range(1, 4096)));
		cfg_write(CFG_FRAME_HEIGHT, COLOR_BITS'($urandom_range(1, 4096)));
		cfg_write(CFG_DRAW_COLOR, COLOR_BITS'($urandom));
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				send_item(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(),
					rand_coord());
				sent++;
			end else begin
				if ($urandom_range(1))
					xs = $urandom_range(63);
				else
					xs = rand_coord();
				if ($urandom_range(1))
					ys = $urandom_range(63);
				else
					ys = rand_coord();
				if (pick < 12) begin
					// long line, cut short by the next start
					xe = rand_coord();
					ye = rand_coord();
					ticks = $urandom_range(6);
				end else begin
					xe = clamp_coord(xs + int'($urandom_range(30)) - 15);
					ye = clamp_coord(ys + int'($urandom_range(30)) - 15);
					ticks = line_length(xs, ys, xe, ye);
					if ($urandom_range(9) == 0)
						ticks = $urandom_range(ticks);
					else if ($urandom_range(9) == 0)
						ticks++;
				end
				send_line(xs, ys, xe, ye, ticks);
				sent += ticks + 1;
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		kind      = KIND_START;
		x_start   = '0;
		y_start   = '0;
		x_end     = '0;
		y_end     = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data  = '0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_lines();
		test_register_settings();
		test_random_traffic(15, 70, 380);
		test_random_traffic(70, 15, 380);
		test_random_traffic(0, 0, 380);
		settle_block();
		if (pending_pixels.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("line_rasterizer_tb: clean");
		else
			$display("line_rasterizer_tb: errors");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
+incdir+hdl
hdl/lr_pkg.sv
hdl/lr_front.sv
hdl/lr_fifo.sv
hdl/lr_back.sv
hdl/line_rasterizer.sv
tb/sv/line_rasterizer_tb.sv
